@@ hdl/cpu8_pkg.sv @@
// shared types, command codes and constants of the 8-bit alu and register unit
package cpu8_pkg;

    typedef enum logic [5:0] {
        CMD_LDA = 6'd0,
        CMD_LDX = 6'd1,
        CMD_LDY = 6'd2,
        CMD_STA = 6'd3,
        CMD_STX = 6'd4,
        CMD_STY = 6'd5,
        CMD_TAX = 6'd6,
        CMD_TAY = 6'd7,
        CMD_TXA = 6'd8,
        CMD_TYA = 6'd9,
        CMD_TSX = 6'd10,
        CMD_TXS = 6'd11,
        CMD_NOP = 6'd12,
        CMD_ADC = 6'd13,
        CMD_SBC = 6'd14,
        CMD_INC = 6'd15,
        CMD_DEC = 6'd16,
        CMD_INX = 6'd17,
        CMD_INY = 6'd18,
        CMD_DEX = 6'd19,
        CMD_DEY = 6'd20,
        CMD_ASL = 6'd21,
        CMD_LSR = 6'd22,
        CMD_ROL = 6'd23,
        CMD_ROR = 6'd24,
        CMD_AND = 6'd25,
        CMD_ORA = 6'd26,
        CMD_EOR = 6'd27,
        CMD_BIT = 6'd28,
        CMD_CMP = 6'd29,
        CMD_CPX = 6'd30,
        CMD_CPY = 6'd31,
        CMD_PHA = 6'd32,
        CMD_PLA = 6'd33,
        CMD_PHP = 6'd34,
        CMD_PLP = 6'd35,
        CMD_CLC = 6'd36,
        CMD_SEC = 6'd37,
        CMD_CLI = 6'd38,
        CMD_SEI = 6'd39,
        CMD_CLD = 6'd40,
        CMD_SED = 6'd41,
        CMD_CLV = 6'd42
    } cmd_t;

    typedef enum logic [1:0] {
        STK_NONE = 2'd0,
        STK_PUSH = 2'd1,
        STK_PULL = 2'd2
    } stack_op_t;

    // bit positions in the status byte
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] PUSH_EXTRA = 8'h30;
    localparam logic [7:0] SP_RESET   = 8'hFD;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] sp;
    } regs_t;

    typedef struct packed {
        logic [7:0] write_data;
        logic       mem_write;
        logic [1:0] stack_access;
        logic [7:0] stack_offset;
    } bus_req_t;

endpackage

@@ hdl/cpu8_op_if.sv @@
// operation channel: command word with its operand byte
interface cpu8_op_if;
    logic       valid;
    logic       ready;
    logic [5:0] command;
    logic [7:0] operand;
    logic       on_accumulator;

    modport source (output valid, output command, output operand, output on_accumulator,
                    input ready);
    modport sink   (input valid, input command, input operand, input on_accumulator,
                    output ready);
endinterface

@@ hdl/cpu8_res_if.sv @@
// result channel: bus request and register file after each operation
interface cpu8_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] write_data;
    logic       mem_write;
    logic [1:0] stack_access;
    logic [7:0] stack_offset;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] flags_out;
    logic [7:0] sp_out;

    modport source (output valid, output write_data, output mem_write, output stack_access,
                    output stack_offset, output acc_out, output x_out, output y_out,
                    output flags_out, output sp_out, input ready);
    modport sink   (input valid, input write_data, input mem_write, input stack_access,
                    input stack_offset, input acc_out, input x_out, input y_out,
                    input flags_out, input sp_out, output ready);
endinterface

@@ hdl/cpu8_exec.sv @@
// single-pass execute logic: next register file and bus request for one command
module cpu8_exec
    import cpu8_pkg::*;
(
    input  regs_t      cur,
    input  logic [5:0] command,
    input  logic [7:0] operand,
    input  logic       on_accumulator,
    output regs_t      nxt,
    output bus_req_t   req
);

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q         = p;
        q[FLAG_Z] = (v == 8'd0);
        q[FLAG_N] = v[7];
        return q;
    endfunction

    cmd_t       op;
    logic [7:0] add_m;
    logic [8:0] sum9;
    logic [7:0] cmp_reg;
    logic [8:0] diff9;
    logic [7:0] shift_src;
    logic [7:0] shift_res;
    logic       shift_c;
    logic [7:0] mem_inc;
    logic [7:0] mem_dec;

    assign op = cmd_t'(command);

    always_comb
    begin
        // sbc is adc of the inverted operand
        add_m = (op == CMD_SBC) ? ~operand : operand;
        sum9  = {1'b0, cur.a} + {1'b0, add_m} + {8'd0, cur.p[FLAG_C]};

        case (op)
            CMD_CPX: cmp_reg = cur.x;
            CMD_CPY: cmp_reg = cur.y;
            default: cmp_reg = cur.a;
        endcase
        diff9 = {1'b0, cmp_reg} - {1'b0, operand};

        shift_src = on_accumulator ? cur.a : operand;
        case (op)
            CMD_ASL:
            begin
                shift_res = {shift_src[6:0], 1'b0};
                shift_c   = shift_src[7];
            end
            CMD_ROL:
            begin
                shift_res = {shift_src[6:0], cur.p[FLAG_C]};
                shift_c   = shift_src[7];
            end
            CMD_ROR:
            begin
                shift_res = {cur.p[FLAG_C], shift_src[7:1]};
                shift_c   = shift_src[0];
            end
            default:
            begin
                shift_res = {1'b0, shift_src[7:1]};
                shift_c   = shift_src[0];
            end
        endcase

        mem_inc = operand + 8'd1;
        mem_dec = operand - 8'd1;
    end

    always_comb
    begin
        nxt = cur;
        req = '0;
        unique case (op)
            CMD_LDA:
            begin
                nxt.a = operand;
                nxt.p = with_nz(cur.p, operand);
            end
            CMD_LDX:
            begin
                nxt.x = operand;
                nxt.p = with_nz(cur.p, operand);
            end
            CMD_LDY:
            begin
                nxt.y = operand;
                nxt.p = with_nz(cur.p, operand);
            end
            CMD_STA:
            begin
                req.write_data = cur.a;
                req.mem_write  = 1'b1;
            end
            CMD_STX:
            begin
                req.write_data = cur.x;
                req.mem_write  = 1'b1;
            end
            CMD_STY:
            begin
                req.write_data = cur.y;
                req.mem_write  = 1'b1;
            end
            CMD_TAX:
            begin
                nxt.x = cur.a;
                nxt.p = with_nz(cur.p, cur.a);
            end
            CMD_TAY:
            begin
                nxt.y = cur.a;
                nxt.p = with_nz(cur.p, cur.a);
            end
            CMD_TXA:
            begin
                nxt.a = cur.x;
                nxt.p = with_nz(cur.p, cur.x);
            end
            CMD_TYA:
            begin
                nxt.a = cur.y;
                nxt.p = with_nz(cur.p, cur.y);
            end
            CMD_TSX:
            begin
                nxt.x = cur.sp;
                nxt.p = with_nz(cur.p, cur.sp);
            end
            CMD_TXS:
            begin
                nxt.sp = cur.x;
            end
            CMD_ADC, CMD_SBC:
            begin
                nxt.a = sum9[7:0];
                nxt.p = with_nz(cur.p, sum9[7:0]);
                nxt.p[FLAG_C] = sum9[8];
                nxt.p[FLAG_V] = ~(cur.a[7] ^ add_m[7]) & (cur.a[7] ^ sum9[7]);
            end
            CMD_INC:
            begin
                req.write_data = mem_inc;
                req.mem_write  = 1'b1;
                nxt.p          = with_nz(cur.p, mem_inc);
            end
            CMD_DEC:
            begin
                req.write_data = mem_dec;
                req.mem_write  = 1'b1;
                nxt.p          = with_nz(cur.p, mem_dec);
            end
            CMD_INX:
            begin
                nxt.x = cur.x + 8'd1;
                nxt.p = with_nz(cur.p, nxt.x);
            end
            CMD_INY:
            begin
                nxt.y = cur.y + 8'd1;
                nxt.p = with_nz(cur.p, nxt.y);
            end
            CMD_DEX:
            begin
                nxt.x = cur.x - 8'd1;
                nxt.p = with_nz(cur.p, nxt.x);
            end
            CMD_DEY:
            begin
                nxt.y = cur.y - 8'd1;
                nxt.p = with_nz(cur.p, nxt.y);
            end
            CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR:
            begin
                nxt.p         = with_nz(cur.p, shift_res);
                nxt.p[FLAG_C] = shift_c;
                if (on_accumulator)
                begin
                    nxt.a = shift_res;
                end
                else
                begin
                    req.write_data = shift_res;
                    req.mem_write  = 1'b1;
                end
            end
            CMD_AND:
            begin
                nxt.a = cur.a & operand;
                nxt.p = with_nz(cur.p, nxt.a);
            end
            CMD_ORA:
            begin
                nxt.a = cur.a | operand;
                nxt.p = with_nz(cur.p, nxt.a);
            end
            CMD_EOR:
            begin
                nxt.a = cur.a ^ operand;
                nxt.p = with_nz(cur.p, nxt.a);
            end
            CMD_BIT:
            begin
                nxt.p[FLAG_Z] = ((cur.a & operand) == 8'd0);
                nxt.p[FLAG_V] = operand[6];
                nxt.p[FLAG_N] = operand[7];
            end
            CMD_CMP, CMD_CPX, CMD_CPY:
            begin
                nxt.p         = with_nz(cur.p, diff9[7:0]);
                nxt.p[FLAG_C] = ~diff9[8];
            end
            CMD_PHA, CMD_PHP:
            begin
                req.write_data   = (op == CMD_PHA) ? cur.a : (cur.p | PUSH_EXTRA);
                req.stack_access = STK_PUSH;
                req.stack_offset = cur.sp;
                nxt.sp           = cur.sp - 8'd1;
            end
            CMD_PLA, CMD_PLP:
            begin
                nxt.sp           = cur.sp + 8'd1;
                req.stack_access = STK_PULL;
                req.stack_offset = nxt.sp;
                if (op == CMD_PLA)
                begin
                    nxt.a = operand;
                    nxt.p = with_nz(cur.p, operand);
                end
                else
                begin
                    nxt.p = operand & ~PUSH_EXTRA;
                end
            end
            CMD_CLC: nxt.p[FLAG_C] = 1'b0;
            CMD_SEC: nxt.p[FLAG_C] = 1'b1;
            CMD_CLI: nxt.p[FLAG_I] = 1'b0;
            CMD_SEI: nxt.p[FLAG_I] = 1'b1;
            CMD_CLD: nxt.p[FLAG_D] = 1'b0;
            CMD_SED: nxt.p[FLAG_D] = 1'b1;
            CMD_CLV: nxt.p[FLAG_V] = 1'b0;
            // nop and unassigned codes change nothing
            default: nxt = cur;
        endcase
    end

endmodule

@@ hdl/cpu8_alu_register_unit.sv @@
// top level: input register, execute pass, register file and result register
//
// Execute unit of an 8-bit 6502-style core. Operation words arrive on ops
// (command, operand byte, accumulator-target bit); each produces exactly one
// word on results: the memory or stack write request and A, X, Y, status
// and stack pointer after the operation.
// An accepted word sits in the input register, is executed in a single
// combinational pass against the register file, and is registered in the
// result register, which drives results.valid.
// One word per cycle is sustained while the receiver is ready; the register
// file feeds back to the execute pass, so dependent operations follow back to back.
// Reset clears A, X, Y and status, sets the stack pointer to 0xFD and
// empties both pipeline registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more word; ops.ready drops only when both are
// full, and no word is lost or executed twice.
module cpu8_alu_register_unit
    import cpu8_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cpu8_op_if.sink       ops,
    cpu8_res_if.source    results
);

    logic       s1_valid_reg;
    logic [5:0] s1_cmd_reg;
    logic [7:0] s1_operand_reg;
    logic       s1_on_acc_reg;

    regs_t      regs_reg;
    regs_t      regs_next;
    bus_req_t   req_next;

    logic       out_valid_reg;
    bus_req_t   out_req_reg;
    regs_t      out_regs_reg;

    logic       s1_adv;
    logic       in_take;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || results.ready);
    assign ops.ready = !s1_valid_reg || s1_adv;
    assign in_take   = ops.valid && ops.ready;

    cpu8_exec u_exec (
        .cur            (regs_reg),
        .command        (s1_cmd_reg),
        .operand        (s1_operand_reg),
        .on_accumulator (s1_on_acc_reg),
        .nxt            (regs_next),
        .req            (req_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            regs_reg      <= '{a: 8'd0, x: 8'd0, y: 8'd0, p: 8'd0, sp: SP_RESET};
        end
        else
        begin
            if (ops.ready)
            begin
                s1_valid_reg <= ops.valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                regs_reg      <= regs_next;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_cmd_reg     <= ops.command;
            s1_operand_reg <= ops.operand;
            s1_on_acc_reg  <= ops.on_accumulator;
        end
        if (s1_adv)
        begin
            out_req_reg  <= req_next;
            out_regs_reg <= regs_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.write_data   = out_req_reg.write_data;
    assign results.mem_write    = out_req_reg.mem_write;
    assign results.stack_access = out_req_reg.stack_access;
    assign results.stack_offset = out_req_reg.stack_offset;
    assign results.acc_out      = out_regs_reg.a;
    assign results.x_out        = out_regs_reg.x;
    assign results.y_out        = out_regs_reg.y;
    assign results.flags_out    = out_regs_reg.p;
    assign results.sp_out       = out_regs_reg.sp;

    // a push reports the pointer before its decrement
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_req_reg.stack_access == STK_PUSH
        |-> out_regs_reg.sp == 8'(out_req_reg.stack_offset - 8'd1))
        else $error("push offset does not match stack pointer");

    // a pull reports the pointer after its increment
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_req_reg.stack_access == STK_PULL
        |-> out_regs_reg.sp == out_req_reg.stack_offset)
        else $error("pull offset does not match stack pointer");

    // memory write and stack access never share one word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_req_reg.mem_write && out_req_reg.stack_access != STK_NONE))
        else $error("memory write and stack access together");

    // status bits 4 and 5 are never stored
    assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg.p[5:4] == 2'b00)
        else $error("unused status bits set");

    // register file only changes when a word is executed
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(regs_reg))
        else $error("register file changed without an executed word");

endmodule
